### rtl/mieu_pkg.sv
// ----------------------------------------------------------------------------
// mieu_pkg: shared codes for the integer execute unit
// Command, opcode and function codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package mieu_pkg;
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LLO   = 6'h18;
  localparam logic [5:0] OP_LHI   = 6'h19;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam int          XLEN   = 32;
  localparam int          CNT_W  = 6;
  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_DFIX = 3'd6;
endpackage
`default_nettype wire

### rtl/mips_integer_execute_unit.sv
// ALU, shift, move, immediate ops and a zero-divisor div go through capture,
// operand read and execute, then output; register write/read commands do the
// access between capture and output; mult/multu add operand setup and the
// radix-2 loop (32 iterations), div/divu also the divide sign fix-up. One word
// in flight; in_ready is low from accept until the result is taken and returns
// the cycle after. Sync active-high reset clears sequencer, HI/LO, GPRs.
// ----------------------------------------------------------------------------
// mips_integer_execute_unit: integer execute unit with HI/LO mult/div
// Combinational ALU plus one shared iterative 34-bit add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none
module mips_integer_execute_unit
  import mieu_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  cmd,
  input  wire  [5:0]  opcode,
  input  wire  [5:0]  funct,
  input  wire  [4:0]  src_a,
  input  wire  [4:0]  src_b,
  input  wire  [4:0]  dest,
  input  wire  [4:0]  shift_amount,
  input  wire  [15:0] imm16,
  input  wire  [31:0] wdata,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        reg_written,
  output logic [4:0]  written_index,
  output logic [31:0] written_value,
  output logic [31:0] hi_now,
  output logic [31:0] lo_now,
  output logic [31:0] read_value
);

  // Sequencer state and captured input word
  logic [2:0]  state;
  logic [1:0]  c_cmd;
  logic [5:0]  c_op, c_fn;
  logic [4:0]  c_a, c_b, c_d, c_sh;
  logic [15:0] c_imm;
  logic [31:0] c_wdata;

  // Register file: array of flops, valid bits give zero reset
  logic [31:0] gpr [32];
  logic [31:0] gpr_vld;
  logic [31:0] hi, lo;

  // Operand latches (read in ST_EXEC)
  logic [31:0] opa, opb;

  // Shared iterative unit: acc holds partial remainder / high product
  logic [31:0] acc, sreg, divs;
  logic [CNT_W-1:0] cnt;
  logic        neg_q, neg_r;

  function automatic logic [31:0] rdg(input logic [31:0] vld, input logic [4:0] i,
                                      input logic [31:0] d);
    rdg = (vld[i] && i != 5'd0) ? d : 32'd0;
  endfunction

  logic [31:0] rs_val, rt_val;
  assign rs_val = rdg(gpr_vld, c_a, gpr[c_a]);
  assign rt_val = rdg(gpr_vld, c_b, gpr[c_b]);

  // Combinational ALU result
  logic        alu_wr;
  logic [4:0]  alu_idx;
  logic [31:0] alu_val;
  logic [31:0] sext, zext;
  logic [4:0]  va;
  assign sext = {{16{c_imm[15]}}, c_imm};
  assign zext = {16'd0, c_imm};
  assign va   = opa[4:0];

  always_comb begin
    alu_wr  = 1'b0;
    alu_idx = c_d;
    alu_val = 32'd0;
    if (c_op == OP_RTYPE) begin
      alu_wr = 1'b1;
      case (c_fn)
        FN_SLL:  alu_val = opb << c_sh;
        FN_SRL:  alu_val = opb >> c_sh;
        FN_SRA:  alu_val = 32'($signed(opb) >>> c_sh);
        FN_SLLV: alu_val = opb << va;
        FN_SRLV: alu_val = opb >> va;
        FN_SRAV: alu_val = 32'($signed(opb) >>> va);
        FN_MFHI: alu_val = hi;
        FN_MFLO: alu_val = lo;
        FN_ADD, FN_ADDU: alu_val = opa + opb;
        FN_SUB, FN_SUBU: alu_val = opa - opb;
        FN_AND:  alu_val = opa & opb;
        FN_OR:   alu_val = opa | opb;
        FN_XOR:  alu_val = opa ^ opb;
        FN_NOR:  alu_val = ~(opa | opb);
        FN_SLT:  alu_val = {31'd0, $signed(opa) < $signed(opb)};
        FN_SLTU: alu_val = {31'd0, opa < opb};
        default: alu_wr = 1'b0;
      endcase
    end else begin
      alu_wr  = 1'b1;
      alu_idx = c_b;
      case (c_op)
        OP_ADDI, OP_ADDIU: alu_val = opa + sext;
        OP_SLTI:  alu_val = {31'd0, $signed(opa) < $signed(sext)};
        OP_SLTIU: alu_val = {31'd0, opa < sext};
        OP_ANDI:  alu_val = opa & zext;
        OP_ORI:   alu_val = opa | zext;
        OP_XORI:  alu_val = opa ^ zext;
        OP_LLO:   alu_val = {opb[31:16], c_imm};
        OP_LHI:   alu_val = {c_imm, opb[15:0]};
        default:  alu_wr = 1'b0;
      endcase
    end
  end

  // Shared add/subtract step: multiply adds the multiplicand, divide subtracts
  // the divisor from the shifted partial remainder (two's complement, carry in)
  logic        div_mode;
  logic [33:0] step_a, step_b, step_sum;
  assign div_mode = (state == ST_DIV);
  assign step_a   = div_mode ? {1'b0, acc, sreg[31]} : {2'b0, acc};
  assign step_b   = div_mode ? ~{2'b0, divs} : {2'b0, (sreg[0] ? opb : 32'd0)};
  assign step_sum = step_a + step_b + {33'd0, div_mode};
  logic [32:0] div_shift;
  assign div_shift = {acc, sreg[31]};

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      gpr_vld   <= 32'd0;
      hi        <= 32'd0;
      lo        <= 32'd0;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) begin
          c_cmd <= cmd; c_op <= opcode; c_fn <= funct; c_a <= src_a;
          c_b <= src_b; c_d <= dest; c_sh <= shift_amount; c_imm <= imm16;
          c_wdata <= wdata;
          state <= ST_EXEC;
          // operands latched next cycle from captured indices
        end
        ST_EXEC: begin
          opa <= rs_val; opb <= rt_val;
          reg_written <= 1'b0; written_index <= 5'd0; written_value <= 32'd0;
          read_value <= 32'd0;
          state <= ST_OUT;
          if (c_cmd == CMD_WRITE) begin
            if (c_d != 5'd0) begin
              gpr[c_d] <= c_wdata; gpr_vld[c_d] <= 1'b1;
              reg_written <= 1'b1; written_index <= c_d; written_value <= c_wdata;
            end
          end else if (c_cmd == CMD_READ) begin
            read_value <= rs_val;
          end else if (c_cmd == CMD_EXEC) begin
            state <= ST_FIX; // ALU runs in ST_FIX on latched operands
          end
        end
        ST_FIX: begin
          state <= ST_OUT;
          if (c_op == OP_RTYPE && c_fn == FN_MTHI) hi <= opa;
          else if (c_op == OP_RTYPE && c_fn == FN_MTLO) lo <= opa;
          else if (c_op == OP_RTYPE && (c_fn == FN_MULT || c_fn == FN_MULTU)) begin
            neg_q <= (c_fn == FN_MULT) && (opa[31] ^ opb[31]);
            sreg  <= (c_fn == FN_MULT && opa[31]) ? -opa : opa;
            opb   <= (c_fn == FN_MULT && opb[31]) ? -opb : opb;
            acc   <= 32'd0; cnt <= '0;
            state <= ST_MUL;
          end else if (c_op == OP_RTYPE && (c_fn == FN_DIV || c_fn == FN_DIVU)) begin
            if (opb != 32'd0) begin
              neg_q <= (c_fn == FN_DIV) && (opa[31] ^ opb[31]);
              neg_r <= (c_fn == FN_DIV) && opa[31];
              sreg  <= (c_fn == FN_DIV && opa[31]) ? -opa : opa;
              divs  <= (c_fn == FN_DIV && opb[31]) ? -opb : opb;
              acc   <= 32'd0; cnt <= '0;
              state <= ST_DIV;
            end
          end else if (alu_wr && alu_idx != 5'd0) begin
            gpr[alu_idx] <= alu_val; gpr_vld[alu_idx] <= 1'b1;
            reg_written <= 1'b1; written_index <= alu_idx; written_value <= alu_val;
          end
        end
        ST_MUL: begin
          // shift-add: {acc,sreg} >>= 1 after conditional add
          acc  <= step_sum[32:1];
          sreg <= {step_sum[0], sreg[31:1]};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(XLEN - 1)) begin
            if (neg_q) begin
              {hi, lo} <= -{step_sum[32:1], step_sum[0], sreg[31:1]};
            end else begin
              {hi, lo} <= {step_sum[32:1], step_sum[0], sreg[31:1]};
            end
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!step_sum[33]) begin
            acc  <= step_sum[31:0];
            sreg <= {sreg[30:0], 1'b1};
          end else begin
            acc  <= div_shift[31:0];
            sreg <= {sreg[30:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(XLEN - 1)) state <= ST_DFIX;
        end
        ST_DFIX: begin
          // divide sign fix-up
          lo <= neg_q ? -sreg : sreg;
          hi <= neg_r ? -acc : acc;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hi_now = hi;
  assign lo_now = lo;

  // Assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_only_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT)) else $error("valid outside output state");
  a_r0_zero: assert property (@(posedge clk) disable iff (rst)
    reg_written && out_valid |-> (written_index != 5'd0)) else $error("r0 written");

endmodule
`default_nettype wire
